>>> src/trm_pkg.sv
// Package for the tagged receive matcher.
// Holds the queue geometry, operation and status codes, and the structs
// passed between the top level and the matcher cells. No dependencies.
package trm_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int SRC_W       = 16;
    localparam int SEQ_W       = 32;

    typedef enum logic [1:0] {
        OP_POST   = 2'd0,
        OP_MATCH  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_PEEK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_POSTED     = 3'd0,
        ST_FULL       = 3'd1,
        ST_MATCHED    = 3'd2,
        ST_NO_MATCH   = 3'd3,
        ST_CANCELLED  = 3'd4,
        ST_NOT_FOUND  = 3'd5,
        ST_NO_MESSAGE = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    // Operation broadcast to every cell while a scan runs.
    typedef struct packed {
        t_op               op;
        logic              directed;
        logic [63:0]       tag;
        logic [63:0]       ignore_mask;
        logic [SRC_W-1:0]  source;
        logic              source_any;
        logic [31:0]       context_id;
        logic [63:0]       buffer_address;
        logic [31:0]       buffer_length;
        logic [SEQ_W-1:0]  next_seq;
    } t_query;

    // Best candidate handed from cell to cell. For a post, found means a
    // free slot has already been taken further up the chain.
    typedef struct packed {
        logic              found;
        logic [SEQ_W-1:0]  age;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       context_id;
        logic [63:0]       tag;
        logic [63:0]       buffer_address;
        logic [31:0]       buffer_length;
    } t_cand;

endpackage

>>> src/trm_cell.sv
// One queue slot of the tagged receive matcher with its compare logic.
// Depends on trm_pkg; instantiated in a chain by the top level.
module trm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [trm_pkg::IDX_W-1:0] i_idx,
    input  trm_pkg::t_query           i_query,
    input  logic                      i_wave,
    input  trm_pkg::t_cand            i_cand,
    input  logic                      i_remove,
    input  logic [trm_pkg::IDX_W-1:0] i_remove_idx,
    output logic                      o_wave,
    output trm_pkg::t_cand            o_cand
);

    logic                        r_valid;
    logic [63:0]                 r_tag;
    logic [63:0]                 r_ignore;
    logic [trm_pkg::SRC_W-1:0]   r_source;
    logic                        r_source_any;
    logic [31:0]                 r_context;
    logic [63:0]                 r_buffer_address;
    logic [31:0]                 r_buffer_length;
    logic [trm_pkg::SEQ_W-1:0]   r_seq;
    logic                        r_wave;
    trm_pkg::t_cand              r_cand;
    trm_pkg::t_cand              n_cand;
    logic [trm_pkg::SEQ_W-1:0]   w_age;
    logic                        w_hit;
    logic                        w_take;
    logic                        w_write;

    // Age relative to the next sequence number, modulo the counter width.
    assign w_age = i_query.next_seq - r_seq;

    // Hit for match or cancel against this slot.
    always_comb begin
        w_hit = 1'b0;
        case (i_query.op)
            trm_pkg::OP_MATCH: begin
                w_hit = r_valid
                    && ((r_tag | r_ignore) == (i_query.tag | r_ignore))
                    && (!i_query.directed || r_source_any || (r_source == i_query.source));
            end
            trm_pkg::OP_CANCEL: begin
                w_hit = r_valid && (r_context == i_query.context_id);
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    assign w_take  = w_hit && (!i_cand.found || (w_age > i_cand.age));
    assign w_write = i_wave && (i_query.op == trm_pkg::OP_POST)
                     && !r_valid && !i_cand.found;

    // Candidate update: a post claims the first free slot, match and cancel
    // keep the strictly oldest hit.
    always_comb begin
        n_cand = i_cand;
        if (i_query.op == trm_pkg::OP_POST) begin
            if (!r_valid) begin
                n_cand.found = 1'b1;
            end
        end else if (w_take) begin
            n_cand.found          = 1'b1;
            n_cand.age            = w_age;
            n_cand.idx            = i_idx;
            n_cand.context_id     = r_context;
            n_cand.tag            = r_tag;
            n_cand.buffer_address = r_buffer_address;
            n_cand.buffer_length  = r_buffer_length;
        end
    end

    // Slot valid flag and scan pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wave  <= 1'b0;
        end else begin
            r_wave <= i_wave;
            if (w_write) begin
                r_valid <= 1'b1;
            end else if (i_remove && (i_remove_idx == i_idx)) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Slot payload, written by a post that lands here.
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (w_write) begin
            r_tag            <= i_query.tag;
            r_ignore         <= i_query.ignore_mask;
            r_source         <= i_query.source;
            r_source_any     <= i_query.source_any;
            r_context        <= i_query.context_id;
            r_buffer_address <= i_query.buffer_address;
            r_buffer_length  <= i_query.buffer_length;
            r_seq            <= i_query.next_seq;
        end
    end

    assign o_wave = r_wave;
    assign o_cand = r_cand;

endmodule

>>> src/tagged_receive_matcher_unit.sv
// Top level of the tagged receive matcher: handshakes, control and the
// chain of trm_cell slots. Depends on trm_pkg and trm_cell.
//
// Channel  Direction  Handshake                     Payload
// cfg      in         i_cfg_valid / o_cfg_ready     i_cfg_directed_receive
// in       in         i_in_valid / o_in_ready       operation, tag, mask, source, ...
// out      out        o_out_valid / i_out_ready     status and result fields
//
// The result is offered once the input transaction has been accepted and
// one scan pulse has walked the cell chain, one slot per cycle, carrying the
// best candidate. The next transaction is taken in the cycle after the result
// has been taken, so the block works on one transaction at a time.
// Reset is synchronous and clears all slot valid flags and the sequence
// counter at once. A stalled output holds the block in its output state.
module tagged_receive_matcher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_directed_receive,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_tag,
    input  logic [63:0] i_ignore_mask,
    input  logic [15:0] i_source_address,
    input  logic        i_source_any,
    input  logic [31:0] i_context_id,
    input  logic [63:0] i_buffer_address,
    input  logic [31:0] i_buffer_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_result_context,
    output logic [63:0] o_result_tag,
    output logic [63:0] o_result_buffer_address,
    output logic [31:0] o_result_buffer_length
);

    trm_pkg::t_state             r_state;
    trm_pkg::t_state             n_state;
    logic                        r_directed;
    logic [trm_pkg::SEQ_W-1:0]   r_next_seq;
    trm_pkg::t_query             r_query;
    logic                        r_start;
    logic                        r_remove;
    logic [trm_pkg::IDX_W-1:0]   r_remove_idx;
    trm_pkg::t_status            r_status;
    logic [31:0]                 r_res_context;
    logic [63:0]                 r_res_tag;
    logic [63:0]                 r_res_baddr;
    logic [31:0]                 r_res_blen;
    logic                        w_accept;
    logic                        w_done;
    trm_pkg::t_cand              w_last;
    logic                        w_wave [trm_pkg::QUEUE_DEPTH+1];
    trm_pkg::t_cand              w_cand [trm_pkg::QUEUE_DEPTH+1];

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_done      = (r_state == trm_pkg::S_SCAN) && w_wave[trm_pkg::QUEUE_DEPTH];
    assign w_last      = w_cand[trm_pkg::QUEUE_DEPTH];

    // Chain of slots; the scan pulse and candidate enter at slot zero.
    assign w_wave[0] = r_start;
    assign w_cand[0] = '0;

    for (genvar k = 0; k < trm_pkg::QUEUE_DEPTH; k++) begin : g_cell
        trm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (trm_pkg::IDX_W'(k)),
            .i_query      (r_query),
            .i_wave       (w_wave[k]),
            .i_cand       (w_cand[k]),
            .i_remove     (r_remove),
            .i_remove_idx (r_remove_idx),
            .o_wave       (w_wave[k+1]),
            .o_cand       (w_cand[k+1])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            trm_pkg::S_IDLE: if (w_accept) n_state = trm_pkg::S_SCAN;
            trm_pkg::S_SCAN: if (w_done) n_state = trm_pkg::S_OUT;
            trm_pkg::S_OUT:  if (i_out_ready) n_state = trm_pkg::S_IDLE;
            default:         n_state = trm_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            trm_pkg::S_IDLE: o_in_ready  = 1'b1;
            trm_pkg::S_OUT:  o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= trm_pkg::S_IDLE;
            r_directed <= 1'b0;
            r_next_seq <= '0;
            r_start    <= 1'b0;
            r_remove   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_start  <= w_accept;
            r_remove <= w_done && w_last.found
                        && ((r_query.op == trm_pkg::OP_MATCH)
                            || (r_query.op == trm_pkg::OP_CANCEL));
            if (i_cfg_valid && o_cfg_ready) begin
                r_directed <= i_cfg_directed_receive;
            end
            if (w_done && w_last.found && (r_query.op == trm_pkg::OP_POST)) begin
                r_next_seq <= r_next_seq + trm_pkg::SEQ_W'(1);
            end
        end
    end

    // Capture the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query.op             <= trm_pkg::t_op'(i_operation);
            r_query.directed       <= r_directed;
            r_query.tag            <= i_tag;
            r_query.ignore_mask    <= i_ignore_mask;
            r_query.source         <= i_source_address;
            r_query.source_any     <= i_source_any;
            r_query.context_id     <= i_context_id;
            r_query.buffer_address <= i_buffer_address;
            r_query.buffer_length  <= i_buffer_length;
            r_query.next_seq       <= r_next_seq;
        end
    end

    // Result register, loaded when the scan pulse leaves the last slot.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_remove_idx  <= w_last.idx;
            r_res_context <= '0;
            r_res_tag     <= '0;
            r_res_baddr   <= '0;
            r_res_blen    <= '0;
            case (r_query.op)
                trm_pkg::OP_POST: begin
                    r_status <= w_last.found ? trm_pkg::ST_POSTED : trm_pkg::ST_FULL;
                end
                trm_pkg::OP_MATCH: begin
                    r_status <= w_last.found ? trm_pkg::ST_MATCHED : trm_pkg::ST_NO_MATCH;
                    if (w_last.found) begin
                        r_res_context <= w_last.context_id;
                        r_res_tag     <= w_last.tag;
                        r_res_baddr   <= w_last.buffer_address;
                        r_res_blen    <= w_last.buffer_length;
                    end
                end
                trm_pkg::OP_CANCEL: begin
                    r_status <= w_last.found ? trm_pkg::ST_CANCELLED : trm_pkg::ST_NOT_FOUND;
                    if (w_last.found) begin
                        r_res_context <= w_last.context_id;
                        r_res_tag     <= w_last.tag;
                    end
                end
                default: begin
                    r_status      <= trm_pkg::ST_NO_MESSAGE;
                    r_res_context <= r_query.context_id;
                    r_res_tag     <= r_query.tag;
                end
            endcase
        end
    end

    assign o_status                = r_status;
    assign o_result_context        = r_res_context;
    assign o_result_tag            = r_res_tag;
    assign o_result_buffer_address = r_res_baddr;
    assign o_result_buffer_length  = r_res_blen;

`ifndef ASSERT_OFF
    // A slot is removed only right after a scan has finished.
    a_remove_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remove |-> (r_state == trm_pkg::S_OUT) && $past(r_state == trm_pkg::S_SCAN))
        else $error("slot removal outside the end of a scan");

    // The scan pulse leaves the chain only while scanning.
    a_wave_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wave[trm_pkg::QUEUE_DEPTH] |-> (r_state == trm_pkg::S_SCAN))
        else $error("scan pulse outside a scan");

    // Input and output are never offered in the same cycle.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");
`endif

endmodule

>>> tb/tb_tagged_receive_matcher_unit.sv
// Self-checking testbench for tagged_receive_matcher_unit.
// Predicts every result with its own model of the posted receive queue and
// checks the outputs field by field. Depends on trm_pkg and the RTL only.
module tb_tagged_receive_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import trm_pkg::*;

    typedef struct {
        t_op         op;
        logic [63:0] tag;
        logic [63:0] mask;
        logic [15:0] src;
        logic        any;
        logic [31:0] ctx;
        logic [63:0] baddr;
        logic [31:0] blen;
    } t_request;

    typedef struct {
        t_status     status;
        logic [31:0] ctx;
        logic [63:0] tag;
        logic [63:0] baddr;
        logic [31:0] blen;
    } t_answer;

    localparam int STALL_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_directed_receive = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = '0;
    logic [63:0] i_tag = '0;
    logic [63:0] i_ignore_mask = '0;
    logic [15:0] i_source_address = '0;
    logic        i_source_any = 1'b0;
    logic [31:0] i_context_id = '0;
    logic [63:0] i_buffer_address = '0;
    logic [31:0] i_buffer_length = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_result_context;
    logic [63:0] o_result_tag;
    logic [63:0] o_result_buffer_address;
    logic [31:0] o_result_buffer_length;

    tagged_receive_matcher_unit DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the receive queue.
    logic        slot_used [QUEUE_DEPTH];
    t_request    slot_req [QUEUE_DEPTH];
    logic [31:0] slot_seq [QUEUE_DEPTH];
    logic [31:0] post_count;
    logic        directed_mode;

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    logic     in_taken = 1'b0;
    logic     calm = 1'b0;
    int       errors = 0;
    int       quiet_cycles = 0;

    // Applies one transaction to the shadow queue and returns its answer.
    function automatic t_answer predict_answer(t_request r);
        t_answer a;
        int      sel;
        logic    hit;
        sel = -1;
        a = '{ST_POSTED, '0, '0, '0, '0};
        case (r.op)
            OP_POST: begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (sel < 0 && !slot_used[i]) sel = i;
                if (sel < 0) begin
                    a.status = ST_FULL;
                end else begin
                    slot_used[sel] = 1'b1;
                    slot_req[sel] = r;
                    slot_seq[sel] = post_count;
                    post_count = post_count + 1;
                end
            end
            OP_MATCH, OP_CANCEL: begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (r.op == OP_MATCH) begin
                        hit = ((slot_req[i].tag | slot_req[i].mask) ==
                               (r.tag | slot_req[i].mask));
                        if (directed_mode)
                            hit = hit && (slot_req[i].any || slot_req[i].src == r.src);
                    end else begin
                        hit = (slot_req[i].ctx == r.ctx);
                    end
                    if (slot_used[i] && hit && (sel < 0 ||
                        (post_count - slot_seq[i]) > (post_count - slot_seq[sel])))
                        sel = i;
                end
                if (sel < 0) begin
                    a.status = (r.op == OP_MATCH) ? ST_NO_MATCH : ST_NOT_FOUND;
                end else begin
                    slot_used[sel] = 1'b0;
                    a.ctx = slot_req[sel].ctx;
                    a.tag = slot_req[sel].tag;
                    if (r.op == OP_MATCH) begin
                        a.status = ST_MATCHED;
                        a.baddr = slot_req[sel].baddr;
                        a.blen = slot_req[sel].blen;
                    end else begin
                        a.status = ST_CANCELLED;
                    end
                end
            end
            default: begin
                a.status = ST_NO_MESSAGE;
                a.ctx = r.ctx;
                a.tag = r.tag;
            end
        endcase
        return a;
    endfunction

    // Driver: presents the next request at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
                t_request r;
                r = pending_requests.pop_front();
                i_operation <= r.op;
                i_tag <= r.tag;
                i_ignore_mask <= r.mask;
                i_source_address <= r.src;
                i_source_any <= r.any;
                i_context_id <= r.ctx;
                i_buffer_address <= r.baddr;
                i_buffer_length <= r.blen;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && (calm || $urandom_range(99) >= 25);
    end

    // Monitor: records accepted requests and checks accepted results.
    always @(posedge i_clk) begin
        in_taken = i_in_valid && o_in_ready;
        if (in_taken) begin
            t_request r;
            r = '{t_op'(i_operation), i_tag, i_ignore_mask, i_source_address,
                  i_source_any, i_context_id, i_buffer_address, i_buffer_length};
            expected_answers.push_back(predict_answer(r));
        end
        if (o_out_valid && i_out_ready) begin
            if (expected_answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result, status %0d", o_status);
            end else begin
                t_answer e;
                e = expected_answers.pop_front();
                if (o_status !== e.status || o_result_context !== e.ctx ||
                    o_result_tag !== e.tag || o_result_buffer_address !== e.baddr ||
                    o_result_buffer_length !== e.blen) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %0d %h %h %h %h, got %0d %h %h %h %h",
                                 e.status, e.ctx, e.tag, e.baddr, e.blen, o_status,
                                 o_result_context, o_result_tag, o_result_buffer_address,
                                 o_result_buffer_length);
                end
            end
        end
        // Watchdog on cycles with no transaction on any channel.
        if (in_taken || (o_out_valid && i_out_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    logic [63:0] tag_pool [8];
    logic [15:0] src_pool [4];
    logic [31:0] ctx_pool [4];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random request; post_weight biases toward filling the queue.
    function automatic t_request random_request(int post_weight);
        t_request r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < post_weight) r.op = OP_POST;
        else if (pick < post_weight + (100 - post_weight) / 2) r.op = OP_MATCH;
        else if (pick < 92) r.op = OP_CANCEL;
        else r.op = OP_PEEK;
        r.tag = ($urandom_range(9) == 0) ? rand64() : tag_pool[$urandom_range(7)];
        case ($urandom_range(3))
            0: r.mask = '0;
            1: r.mask = ($urandom_range(9) == 0) ? '1 : rand64() & rand64() & rand64();
            2: r.mask = rand64() & rand64() & rand64() & rand64();
            default: r.mask = rand64();
        endcase
        r.src = ($urandom_range(7) == 0) ? 16'($urandom) : src_pool[$urandom_range(3)];
        r.any = $urandom_range(2) == 0;
        r.ctx = ($urandom_range(7) == 0) ? $urandom : ctx_pool[$urandom_range(3)];
        r.baddr = rand64();
        r.blen = $urandom;
        return r;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_requests.size() > 0 || i_in_valid || expected_answers.size() > 0);
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_directed_receive <= mode;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        directed_mode = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(logic mode, int count, int post_weight);
        write_mode(mode);
        for (int i = 0; i < count; i++) pending_requests.push_back(random_request(post_weight));
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
        post_count = '0;
        directed_mode = 1'b0;
        foreach (tag_pool[i]) tag_pool[i] = rand64();
        foreach (src_pool[i]) src_pool[i] = 16'($urandom);
        foreach (ctx_pool[i]) ctx_pool[i] = $urandom;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, every operation, the special cases.
        calm = 1'b1;
        write_mode(1'b0);
        pending_requests.push_back('{OP_POST, '1, '0, '1, 1'b0, '1, '1, '1});
        pending_requests.push_back('{OP_POST, '0, '1, '0, 1'b1, '0, '0, '0});
        pending_requests.push_back('{OP_PEEK, '1, '1, '1, 1'b1, '1, '1, '1});
        pending_requests.push_back('{OP_PEEK, '0, '0, '0, 1'b0, '0, '0, '0});
        pending_requests.push_back('{OP_MATCH, '0, '0, '0, 1'b1, '0, '0, '0});
        pending_requests.push_back('{OP_MATCH, '0, '0, '0, 1'b0, '0, '0, '0});
        pending_requests.push_back('{OP_CANCEL, '0, '0, '0, 1'b0, '1, '0, '0});
        pending_requests.push_back('{OP_CANCEL, '0, '0, '0, 1'b0, '1, '0, '0});
        pending_requests.push_back('{OP_POST, 64'h5a, 64'hf, 16'h1234, 1'b0, 32'h7, 64'h10, 32'h20});
        pending_requests.push_back('{OP_POST, 64'h55, 64'hf, 16'h4321, 1'b0, 32'h7, 64'h30, 32'h40});
        pending_requests.push_back('{OP_MATCH, 64'h53, '0, 16'h4321, 1'b0, '0, '0, '0});
        pending_requests.push_back('{OP_CANCEL, '0, '0, '0, 1'b0, 32'h7, '0, '0});
        pending_requests.push_back('{OP_MATCH, 64'h53, '0, 16'h4321, 1'b0, '0, '0, '0});
        wait_idle();

        // Directed mode: source filter against a specific sender and a wildcard.
        write_mode(1'b1);
        pending_requests.push_back('{OP_POST, 64'h9, '0, 16'h00ff, 1'b0, 32'h1, 64'h1, 32'h1});
        pending_requests.push_back('{OP_POST, 64'h9, '0, 16'h0000, 1'b1, 32'h2, 64'h2, 32'h2});
        pending_requests.push_back('{OP_MATCH, 64'h9, '0, 16'hff00, 1'b0, '0, '0, '0});
        pending_requests.push_back('{OP_MATCH, 64'h9, '0, 16'hff00, 1'b0, '0, '0, '0});
        pending_requests.push_back('{OP_MATCH, 64'h9, '0, 16'h00ff, 1'b0, '0, '0, '0});
        wait_idle();

        // Random part with changing mode; the heavy post phases fill the queue.
        calm = 1'b0;
        random_phase(1'b0, 400, 45);
        calm = 1'b1;
        random_phase(1'b1, 300, 75);
        calm = 1'b0;
        random_phase(1'b1, 450, 75);
        random_phase(1'b0, 300, 40);
        random_phase(1'b1, 300, 50);

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
